/* rtl/core/vector_pair_angle_macros.svh */
// Assertion macros for the vector_pair_angle checker.
// Needs a clk and rst in scope where used.
`ifndef VECTOR_PAIR_ANGLE_MACROS_SVH
`define VECTOR_PAIR_ANGLE_MACROS_SVH

// same-cycle implication
`define VPA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define VPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/vpa_pkg.sv */
// Shared types, constants and the CORDIC arctangent table for vector_pair_angle.
// No dependencies.
`default_nettype none

package vpa_pkg;

  localparam int COORD_W     = 32;
  localparam int TOL_W       = 16;
  localparam int TURN_W      = 19;
  localparam int ACC_FRAC    = 30;
  localparam int PRESCALE_SH = 16;
  localparam int XY_W        = 52;
  localparam int Z_W         = 35;
  localparam int ANG_W       = 33;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 3;

  localparam int ANGLE_FRAC_BITS_DEF = 16;
  localparam int CORDIC_STAGES_DEF   = 18;

  localparam logic [0:0]       REG_ZERO_TOL = 1'b0;
  localparam logic [TOL_W-1:0] TOL_RESET    = 16'd1;

  localparam logic signed [Z_W-1:0] PI_Q30     = 35'sd3373259426;
  localparam logic signed [Z_W-1:0] TWO_PI_Q30 = 35'sd6746518852;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   zero;
  } vec_t;

  typedef struct packed {
    vec_t a;
    vec_t b;
    logic ccw;
    logic near_zero;
  } pipe_t;

  typedef struct packed {
    logic [ANG_W-1:0] a1;
    logic [ANG_W-1:0] a2;
    logic             ccw;
    logic             near_zero;
  } ang_t;

  typedef struct packed {
    logic [ANG_W-1:0] diff;
    logic             ccw;
    logic             near_zero;
  } diff_t;

  // atan(2^-i) in Q30
  function automatic logic signed [Z_W-1:0] atan_q30(input int i);
    logic signed [Z_W-1:0] r;
    case (i)
      0:  r = 35'sh03243F6A8;
      1:  r = 35'sh01DAC6705;
      2:  r = 35'sh00FADBAFC;
      3:  r = 35'sh007F56EA6;
      4:  r = 35'sh003FEAB76;
      5:  r = 35'sh001FFD55B;
      6:  r = 35'sh000FFFAAA;
      7:  r = 35'sh0007FFF55;
      8:  r = 35'sh0003FFFEA;
      9:  r = 35'sh0001FFFFD;
      10: r = 35'sh0000FFFFF;
      11: r = 35'sh00007FFFF;
      12: r = 35'sh00003FFFF;
      13: r = 35'sh00001FFFF;
      14: r = 35'sh00000FFFF;
      15: r = 35'sh000007FFF;
      16: r = 35'sh000003FFF;
      17: r = 35'sh000001FFF;
      18: r = 35'sh000000FFF;
      19: r = 35'sh0000007FF;
      20: r = 35'sh0000003FF;
      21: r = 35'sh0000001FF;
      22: r = 35'sh0000000FF;
      23: r = 35'sh00000007F;
      24: r = 35'sh00000003F;
      25: r = 35'sh00000001F;
      26: r = 35'sh00000000F;
      27: r = 35'sh000000008;
      28: r = 35'sh000000004;
      29: r = 35'sh000000002;
      30: r = 35'sh000000001;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/vpa_pre.sv */
// Input stage: small-vector test, half-turn pre-rotation and prescale.
// Depends on vpa_pkg.
`default_nettype none

module vpa_pre (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  input  wire logic signed [vpa_pkg::COORD_W-1:0]  fx,
  input  wire logic signed [vpa_pkg::COORD_W-1:0]  fy,
  input  wire logic signed [vpa_pkg::COORD_W-1:0]  sx,
  input  wire logic signed [vpa_pkg::COORD_W-1:0]  sy,
  input  wire logic                                ccw,
  input  wire logic        [vpa_pkg::TOL_W-1:0]    tol,
  output      logic                                ready,
  output      logic                                out_valid,
  output      vpa_pkg::pipe_t                      out_data,
  input  wire logic                                nxt_ready
);

  function automatic logic [vpa_pkg::COORD_W-1:0] mag(
    input logic signed [vpa_pkg::COORD_W-1:0] v
  );
    return v[vpa_pkg::COORD_W-1] ? (~v) + 1'b1 : v;
  endfunction

  function automatic vpa_pkg::vec_t prep(
    input logic signed [vpa_pkg::COORD_W-1:0] x,
    input logic signed [vpa_pkg::COORD_W-1:0] y
  );
    vpa_pkg::vec_t          v;
    logic signed [vpa_pkg::XY_W-1:0] xe;
    logic signed [vpa_pkg::XY_W-1:0] ye;
    xe = {{(vpa_pkg::XY_W-vpa_pkg::COORD_W){x[vpa_pkg::COORD_W-1]}}, x};
    ye = {{(vpa_pkg::XY_W-vpa_pkg::COORD_W){y[vpa_pkg::COORD_W-1]}}, y};
    v.zero = (x == '0) && (y == '0);
    if (x[vpa_pkg::COORD_W-1]) begin
      v.x = (-xe) <<< vpa_pkg::PRESCALE_SH;
      v.y = (-ye) <<< vpa_pkg::PRESCALE_SH;
      v.z = vpa_pkg::PI_Q30;
    end else begin
      v.x = xe <<< vpa_pkg::PRESCALE_SH;
      v.y = ye <<< vpa_pkg::PRESCALE_SH;
      v.z = '0;
    end
    return v;
  endfunction

  logic [vpa_pkg::COORD_W-1:0] tol_ext;
  vpa_pkg::pipe_t              d_next;

  assign tol_ext = {{(vpa_pkg::COORD_W-vpa_pkg::TOL_W){1'b0}}, tol};
  assign ready   = !out_valid || nxt_ready;

  always_comb begin
    d_next.a         = prep(fx, fy);
    d_next.b         = prep(sx, sy);
    d_next.ccw       = ccw;
    d_next.near_zero = ((mag(fx) < tol_ext) && (mag(fy) < tol_ext)) ||
                       ((mag(sx) < tol_ext) && (mag(sy) < tol_ext));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && in_valid) begin
      out_data <= d_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/vpa_cstage.sv */
// One vectoring CORDIC iteration applied to both vectors of a transaction.
// Depends on vpa_pkg.
`default_nettype none

module vpa_cstage #(
  parameter int IDX = 0
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire vpa_pkg::pipe_t in_data,
  output      logic           ready,
  output      logic           out_valid,
  output      vpa_pkg::pipe_t out_data,
  input  wire logic           nxt_ready
);

  function automatic vpa_pkg::vec_t step(input vpa_pkg::vec_t v);
    vpa_pkg::vec_t                   r;
    logic signed [vpa_pkg::XY_W-1:0] x;
    logic signed [vpa_pkg::XY_W-1:0] y;
    logic signed [vpa_pkg::XY_W-1:0] dx;
    logic signed [vpa_pkg::XY_W-1:0] dy;
    x  = v.x;
    y  = v.y;
    dx = y >>> IDX;
    dy = x >>> IDX;
    r.zero = v.zero;
    if (!y[vpa_pkg::XY_W-1]) begin
      r.x = x + dx;
      r.y = y - dy;
      r.z = v.z + vpa_pkg::atan_q30(IDX);
    end else begin
      r.x = x - dx;
      r.y = y + dy;
      r.z = v.z - vpa_pkg::atan_q30(IDX);
    end
    return r;
  endfunction

  vpa_pkg::pipe_t d_next;

  assign ready = !out_valid || nxt_ready;

  always_comb begin
    d_next.a         = step(in_data.a);
    d_next.b         = step(in_data.b);
    d_next.ccw       = in_data.ccw;
    d_next.near_zero = in_data.near_zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && in_valid) begin
      out_data <= d_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/vpa_wrap.sv */
// Wraps both CORDIC angles into [0, 2pi); an exact zero vector gets angle 0.
// Depends on vpa_pkg.
`default_nettype none

module vpa_wrap (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire vpa_pkg::pipe_t in_data,
  output      logic           ready,
  output      logic           out_valid,
  output      vpa_pkg::ang_t  out_data,
  input  wire logic           nxt_ready
);

  function automatic logic [vpa_pkg::ANG_W-1:0] wrap(input vpa_pkg::vec_t v);
    logic signed [vpa_pkg::Z_W-1:0] w;
    if (v.z < 0) begin
      w = v.z + vpa_pkg::TWO_PI_Q30;
    end else if (v.z >= vpa_pkg::TWO_PI_Q30) begin
      w = v.z - vpa_pkg::TWO_PI_Q30;
    end else begin
      w = v.z;
    end
    return v.zero ? '0 : w[vpa_pkg::ANG_W-1:0];
  endfunction

  vpa_pkg::ang_t d_next;

  assign ready = !out_valid || nxt_ready;

  always_comb begin
    d_next.a1        = wrap(in_data.a);
    d_next.a2        = wrap(in_data.b);
    d_next.ccw       = in_data.ccw;
    d_next.near_zero = in_data.near_zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && in_valid) begin
      out_data <= d_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/vpa_diff.sv */
// Angle difference second minus first, wrapped into [0, 2pi).
// Depends on vpa_pkg.
`default_nettype none

module vpa_diff (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire vpa_pkg::ang_t in_data,
  output      logic          ready,
  output      logic          out_valid,
  output      vpa_pkg::diff_t out_data,
  input  wire logic          nxt_ready
);

  logic signed [vpa_pkg::ANG_W:0] d;
  logic signed [vpa_pkg::ANG_W:0] dw;
  vpa_pkg::diff_t                 d_next;

  assign ready = !out_valid || nxt_ready;

  always_comb begin
    d  = $signed({1'b0, in_data.a2}) - $signed({1'b0, in_data.a1});
    dw = d[vpa_pkg::ANG_W] ?
         d + $signed(vpa_pkg::TWO_PI_Q30[vpa_pkg::ANG_W:0]) : d;
    d_next.diff      = dw[vpa_pkg::ANG_W-1:0];
    d_next.ccw       = in_data.ccw;
    d_next.near_zero = in_data.near_zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && in_valid) begin
      out_data <= d_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/vpa_round.sv */
// Output stage: orientation, rounding to the output format, small-vector zeroing.
// Depends on vpa_pkg.
`default_nettype none

module vpa_round #(
  parameter int ANGLE_FRAC_BITS = vpa_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire vpa_pkg::diff_t               in_data,
  output      logic                         ready,
  output      logic                         out_valid,
  output      logic [vpa_pkg::TURN_W-1:0]   turn,
  input  wire logic                         nxt_ready
);

  localparam int SHIFT = vpa_pkg::ACC_FRAC - ANGLE_FRAC_BITS;
  localparam int SUM_W = (SHIFT + vpa_pkg::TURN_W > vpa_pkg::ANG_W + 1) ?
                         SHIFT + vpa_pkg::TURN_W : vpa_pkg::ANG_W + 1;
  localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (SHIFT - 1);
  localparam logic [SUM_W-1:0] TWO_PI = SUM_W'(vpa_pkg::TWO_PI_Q30);

  logic [SUM_W-1:0]          o;
  logic [SUM_W-1:0]          sum;
  logic [vpa_pkg::TURN_W-1:0] turn_next;

  assign ready = !out_valid || nxt_ready;

  always_comb begin
    o   = in_data.ccw ? SUM_W'(in_data.diff) : TWO_PI - SUM_W'(in_data.diff);
    sum = o + HALF;
    turn_next = in_data.near_zero ? '0 : sum[SHIFT +: vpa_pkg::TURN_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && in_valid) begin
      turn <= turn_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/vector_pair_angle.sv */
// vector_pair_angle: angle from a first to a second 2D vector (signed Q16.16 in,
// unsigned Q3.16 radians out, 2pi = 411775), both polar angles by vectoring CORDIC.
// Takes one transaction per cycle while result_stall is low. Registers in order:
// input stage, one per CORDIC iteration, wrap, difference, rounding/output
// register. Each stage holds its item until the next one frees, so bubbles
// close up under result_stall and item_stall rises only when every stage is full.
// zero_tolerance sits at byte addresses 0 to 3 of the APB port (paddr[2] low); write it only while idle.
// Depends on vpa_pkg, vpa_pre, vpa_cstage, vpa_wrap, vpa_diff, vpa_round.
`default_nettype none

module vector_pair_angle #(
  parameter int ANGLE_FRAC_BITS = vpa_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES   = vpa_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [vpa_pkg::ADDR_W-1:0]          paddr,
  input  wire logic [vpa_pkg::DATA_W-1:0]          pwdata,
  output      logic [vpa_pkg::DATA_W-1:0]          prdata,
  output      logic                                pready,
  input  wire logic                                item_valid,
  output      logic                                item_stall,
  input  wire logic signed [vpa_pkg::COORD_W-1:0]  first_x,
  input  wire logic signed [vpa_pkg::COORD_W-1:0]  first_y,
  input  wire logic signed [vpa_pkg::COORD_W-1:0]  second_x,
  input  wire logic signed [vpa_pkg::COORD_W-1:0]  second_y,
  input  wire logic                                counter_clock,
  output      logic                                result_valid,
  input  wire logic                                result_stall,
  output      logic [vpa_pkg::TURN_W-1:0]          turn_angle
);

  logic [vpa_pkg::TOL_W-1:0] zero_tolerance;
  logic                      wr_tol;
  logic                      pre_ready;

  vpa_pkg::pipe_t cdat [0:CORDIC_STAGES];
  logic           cval [0:CORDIC_STAGES];
  logic           crdy [0:CORDIC_STAGES];

  vpa_pkg::ang_t  wdat;
  logic           wval;
  vpa_pkg::diff_t ddat;
  logic           dval;
  logic           drdy;
  logic           rrdy;

  assign pready = 1'b1;
  assign wr_tol = psel && penable && pwrite && pready &&
                  (paddr[vpa_pkg::ADDR_W-1] == vpa_pkg::REG_ZERO_TOL);

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_tolerance <= vpa_pkg::TOL_RESET;
    end else if (wr_tol) begin
      zero_tolerance <= pwdata[vpa_pkg::TOL_W-1:0];
    end
  end

  always_comb begin
    if (paddr[vpa_pkg::ADDR_W-1] == vpa_pkg::REG_ZERO_TOL) begin
      prdata = {{(vpa_pkg::DATA_W-vpa_pkg::TOL_W){1'b0}}, zero_tolerance};
    end else begin
      prdata = '0;
    end
  end

  assign item_stall = !pre_ready;

  vpa_pre u_pre (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_valid),
    .fx        (first_x),
    .fy        (first_y),
    .sx        (second_x),
    .sy        (second_y),
    .ccw       (counter_clock),
    .tol       (zero_tolerance),
    .ready     (pre_ready),
    .out_valid (cval[0]),
    .out_data  (cdat[0]),
    .nxt_ready (crdy[0])
  );

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    vpa_cstage #(
      .IDX (k)
    ) u_cstage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cval[k]),
      .in_data   (cdat[k]),
      .ready     (crdy[k]),
      .out_valid (cval[k+1]),
      .out_data  (cdat[k+1]),
      .nxt_ready (crdy[k+1])
    );
  end

  vpa_wrap u_wrap (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cval[CORDIC_STAGES]),
    .in_data   (cdat[CORDIC_STAGES]),
    .ready     (crdy[CORDIC_STAGES]),
    .out_valid (wval),
    .out_data  (wdat),
    .nxt_ready (drdy)
  );

  vpa_diff u_diff (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (wval),
    .in_data   (wdat),
    .ready     (drdy),
    .out_valid (dval),
    .out_data  (ddat),
    .nxt_ready (rrdy)
  );

  vpa_round #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_round (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dval),
    .in_data   (ddat),
    .ready     (rrdy),
    .out_valid (result_valid),
    .turn      (turn_angle),
    .nxt_ready (!result_stall)
  );

endmodule

`default_nettype wire

/* rtl/core/vpa_checker.sv */
// Port-level checks for vector_pair_angle, bound to the top level.
// Depends on vpa_pkg and vector_pair_angle_macros.svh.
`default_nettype none

`include "vector_pair_angle_macros.svh"

module vpa_checker #(
  parameter int ANGLE_FRAC_BITS = vpa_pkg::ANGLE_FRAC_BITS_DEF
) (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       item_valid,
  input wire logic                       item_stall,
  input wire logic                       result_valid,
  input wire logic                       result_stall,
  input wire logic [vpa_pkg::TURN_W-1:0] turn_angle
);

  localparam int SHIFT = vpa_pkg::ACC_FRAC - ANGLE_FRAC_BITS;
  localparam longint TURN_MAX =
    (longint'(vpa_pkg::TWO_PI_Q30) + (longint'(1) << (SHIFT - 1))) >> SHIFT;
  localparam bit MAX_FITS = TURN_MAX < (longint'(1) << vpa_pkg::TURN_W);
  localparam logic [vpa_pkg::TURN_W-1:0] TURN_LIMIT = vpa_pkg::TURN_W'(TURN_MAX);

  `VPA_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(turn_angle), "stalled result changed")

  `VPA_ASSERT_NOW(a_stall_only_when_full, item_stall, result_valid && result_stall, "input stalled while output drains")

  `VPA_ASSERT_NOW(a_turn_range, result_valid, !MAX_FITS || (turn_angle <= TURN_LIMIT), "turn angle above 2pi")

  `VPA_ASSERT_NOW(a_reset_empty, $past(rst), !result_valid, "result valid right after reset")

  logic unused_ok;
  assign unused_ok = item_valid;

endmodule

bind vector_pair_angle vpa_checker #(
  .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_vpa_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .turn_angle   (turn_angle)
);

`default_nettype wire
